/* design/hpr_pkg.sv */
// ----------------------------------------------------------------------------
// Heater pulse regulator package
// Shared widths, phase codes, register indexes and conversion constants.
// ----------------------------------------------------------------------------
package hpr_pkg;

    // Fixed field widths
    localparam int TEMP_W     = 12;
    localparam int PHASE_W    = 3;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Phase codes as reported on the result item
    localparam logic [PHASE_W-1:0] PH_AVG         = 3'd0;
    localparam logic [PHASE_W-1:0] PH_INIT_PULSE  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_INIT_SETTLE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_IDLE        = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PULSE       = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SETTLE      = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PULSE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PULSE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SETTLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE        = 3'd7;

    // Thermistor code to 1/16 degree: (code * 587) / 256 - 978
    localparam int CONV_MUL    = 587;
    localparam int CONV_SHIFT  = 8;
    localparam int CONV_OFFSET = 978;

endpackage

/* design/heater_pulse_regulator.sv */
// ----------------------------------------------------------------------------
// Heater pulse regulator
// Per-tick heating wire control from a thermistor sample, with a startup
// averaging run, a slope-sized initial pulse and hysteresis regulation.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the s_axis channel is one one-second tick carrying the
//   thermistor code. For every item exactly one result item leaves on
//   m_axis: heater drive, converted temperature and the phase of the tick.
//   Registers are written on the cfg channel (always ready); writes are meant
//   only while the block is idle, which the block itself does not enforce.
//   An ordinary tick passes through the S_CONV, S_EVAL and S_OUT states
//   before its result is registered. The tick that ends the averaging run
//   also passes through S_PREP, S_DIV and S_SAT, where the bit-serial
//   divider sizes the initial pulse, one quotient bit per cycle. One item
//   is worked on at a time; s_axis_tready is high only between items.
//   A finished result sits in the output register; the next item may be
//   accepted meanwhile and its result waits until the old one is taken.
//   Reset clears the phase to averaging, the sums and counters, and loads
//   the default register values. A stalled receiver stalls the block.
// ----------------------------------------------------------------------------
module heater_pulse_regulator #(
    parameter int AVG_SAMPLES = 100,
    parameter int COUNT_BITS  = 16,
    parameter int ADC_BITS    = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input items: tdata = adc_code (lowest bits), zero padded
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((ADC_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // Result items: tdata = heater_on [0], temperature [12:1], phase [15:13]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [hpr_pkg::OUT_W-1:0]           m_axis_tdata,
    // Configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hpr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hpr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import hpr_pkg::*;

    // Derived widths
    localparam int T_W      = ADC_BITS + 3;                 // signed temperature
    localparam int EXT_W    = (T_W > TEMP_W) ? T_W : TEMP_W;
    localparam int PROD_W   = ADC_BITS + 10;
    localparam int SCL_W    = PROD_W - CONV_SHIFT;
    localparam int IDX_W    = $clog2(AVG_SAMPLES + 1);
    localparam int SUM_W    = T_W + 7;
    localparam int DIFF_W   = SUM_W + 2;
    localparam int MAG_W    = DIFF_W + 4;
    localparam int TGT_W    = 18;
    localparam int DEN_W    = 12 + IDX_W;
    localparam int STEP_W   = $clog2(MAG_W + 1);
    localparam int CNT_W    = (COUNT_BITS > 10) ? COUNT_BITS : 10;
    localparam int QW       = ((MAG_W > COUNT_BITS) ? MAG_W : COUNT_BITS) + 1;
    localparam int CMP_W    = T_W + 4;
    localparam logic [QW-1:0]    MAXC    = (QW'(1) << COUNT_BITS) - QW'(1);
    localparam logic [TGT_W-1:0] TGT_MUL = TGT_W'(16 * AVG_SAMPLES);

    typedef enum logic [2:0] {
        S_IDLE, S_CONV, S_EVAL, S_PREP, S_DIV, S_SAT, S_OUT
    } t_state;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [CNT_W-1:0]   cnt;
    } t_next_phase;

    // Entering an off phase: zero length goes straight to the idle check.
    function automatic t_next_phase off_next(input logic [9:0] ticks,
                                             input logic [PHASE_W-1:0] ph);
        t_next_phase r;
        if (ticks == 10'd0) begin
            r.phase = PH_IDLE;
            r.cnt   = '0;
        end else begin
            r.phase = ph;
            r.cnt   = CNT_W'(ticks - 10'd1);
        end
        return r;
    endfunction

    t_state                 r_state;
    logic [ADC_BITS-1:0]    r_code;
    logic signed [T_W-1:0]  r_temp;
    logic [PHASE_W-1:0]     r_phase;
    logic [CNT_W-1:0]       r_cnt;
    logic signed [SUM_W-1:0] r_sum;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_res_heater;
    logic [PHASE_W-1:0]     r_res_phase;
    logic                   r_m_valid;
    logic [OUT_W-1:0]       r_m_data;

    // Divider state
    logic                   r_neg;
    logic [MAG_W-1:0]       r_quo;
    logic [DEN_W:0]         r_rem;
    logic [DEN_W-1:0]       r_den;
    logic [STEP_W-1:0]      r_step;

    // Configuration registers
    logic [6:0]             r_target;
    logic [4:0]             r_cutoff;
    logic [4:0]             r_far;
    logic [9:0]             r_long;
    logic [9:0]             r_short;
    logic [9:0]             r_settle;
    logic [9:0]             r_start_settle;
    logic [11:0]            r_slope;

    // Temperature conversion from the registered code
    logic [PROD_W-1:0]      w_prod;
    logic [SCL_W-1:0]       w_scaled;
    logic signed [T_W-1:0]  w_temp;
    logic signed [EXT_W-1:0] w_temp_ext;

    assign w_prod     = PROD_W'(r_code) * PROD_W'(CONV_MUL);
    assign w_scaled   = w_prod[PROD_W-1:CONV_SHIFT];
    assign w_temp     = $signed({1'b0, w_scaled}) - T_W'(CONV_OFFSET);
    assign w_temp_ext = EXT_W'(r_temp);

    // Regulation thresholds
    logic signed [CMP_W-1:0] w_t, w_tgt, w_cut, w_far;
    logic                    w_below, w_far_below;
    logic [9:0]              w_up;

    assign w_t         = CMP_W'(r_temp);
    assign w_tgt       = $signed(CMP_W'({r_target, 4'b0}));
    assign w_cut       = $signed(CMP_W'({r_cutoff, 4'b0}));
    assign w_far       = $signed(CMP_W'({r_far, 4'b0}));
    assign w_below     = w_t < (w_tgt - w_cut);
    assign w_far_below = (w_t + w_far) < w_tgt;
    assign w_up        = w_far_below ? r_long : r_short;

    // Initial pulse numerator magnitude and denominator
    logic [TGT_W-1:0]         w_tgt_total;
    logic signed [DIFF_W-1:0] w_diff;
    logic [DIFF_W-1:0]        w_diff_abs;
    logic [11:0]              w_slope;
    logic [IDX_W-1:0]         w_idx_next;

    assign w_tgt_total = TGT_W'(r_target) * TGT_MUL;
    assign w_diff      = $signed(DIFF_W'(w_tgt_total)) - DIFF_W'(r_sum);
    assign w_diff_abs  = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);
    assign w_slope     = (r_slope == 12'd0) ? 12'd1 : r_slope;
    assign w_idx_next  = r_idx + IDX_W'(1);

    // Subtract-and-compare step of the divider
    logic [DEN_W:0] w_shift;
    logic           w_fit;

    assign w_shift = {r_rem[DEN_W-1:0], r_quo[MAG_W-1]};
    assign w_fit   = w_shift >= {1'b0, r_den};

    // Saturated quotient
    logic [QW-1:0] w_quo_ext;
    logic [QW-1:0] w_quo_sat;

    assign w_quo_ext = QW'(r_quo);
    assign w_quo_sat = (w_quo_ext > MAXC) ? MAXC : w_quo_ext;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign o_cfg_ready   = 1'b1;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target       <= 7'd45;
            r_cutoff       <= 5'd1;
            r_far          <= 5'd5;
            r_long         <= 10'd45;
            r_short        <= 10'd30;
            r_settle       <= 10'd10;
            r_start_settle <= 10'd30;
            r_slope        <= 12'd33;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET:       r_target       <= i_cfg_data[6:0];
                CFG_CUTOFF:       r_cutoff       <= i_cfg_data[4:0];
                CFG_FAR:          r_far          <= i_cfg_data[4:0];
                CFG_LONG_PULSE:   r_long         <= i_cfg_data[9:0];
                CFG_SHORT_PULSE:  r_short        <= i_cfg_data[9:0];
                CFG_SETTLE:       r_settle       <= i_cfg_data[9:0];
                CFG_START_SETTLE: r_start_settle <= i_cfg_data[9:0];
                CFG_SLOPE:        r_slope        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: phase logic, divider iterations and output register
    always_ff @(posedge i_clk) begin
        t_next_phase np;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_AVG;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // A taken result empties the output register unless S_OUT refills it.
            if (r_m_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_code  <= s_axis_tdata[ADC_BITS-1:0];
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_temp  <= w_temp;
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    // The last averaging tick goes on to size the initial pulse.
                    if ((r_phase == PH_AVG) && (w_idx_next >= IDX_W'(AVG_SAMPLES))) begin
                        r_state <= S_PREP;
                    end else begin
                        r_state <= S_OUT;
                    end
                    case (r_phase)
                        PH_AVG: begin
                            r_res_heater <= 1'b1;
                            r_res_phase  <= PH_AVG;
                            r_sum        <= r_sum + SUM_W'(r_temp);
                            r_idx        <= w_idx_next;
                        end
                        PH_INIT_PULSE, PH_PULSE: begin
                            r_res_heater <= 1'b1;
                            r_res_phase  <= r_phase;
                            if (r_cnt == '0) begin
                                if (r_phase == PH_INIT_PULSE) begin
                                    np = off_next(r_start_settle, PH_INIT_SETTLE);
                                end else begin
                                    np = off_next(r_settle, PH_SETTLE);
                                end
                                r_phase <= np.phase;
                                r_cnt   <= np.cnt;
                            end else begin
                                r_cnt <= r_cnt - CNT_W'(1);
                            end
                        end
                        PH_INIT_SETTLE, PH_SETTLE: begin
                            r_res_heater <= 1'b0;
                            r_res_phase  <= r_phase;
                            if (r_cnt == '0) begin
                                r_phase <= PH_IDLE;
                            end else begin
                                r_cnt <= r_cnt - CNT_W'(1);
                            end
                        end
                        default: begin
                            // Idle check, also taken by the unused codes
                            if (w_below) begin
                                r_res_heater <= 1'b1;
                                r_res_phase  <= PH_PULSE;
                                if (w_up == 10'd0) begin
                                    np = off_next(r_settle, PH_SETTLE);
                                    r_phase <= np.phase;
                                    r_cnt   <= np.cnt;
                                end else begin
                                    r_phase <= PH_PULSE;
                                    r_cnt   <= CNT_W'(w_up - 10'd1);
                                end
                            end else begin
                                r_phase      <= PH_IDLE;
                                r_res_heater <= 1'b0;
                                r_res_phase  <= PH_IDLE;
                            end
                        end
                    endcase
                end
                S_PREP: begin
                    // Load the divider with |num| and slope * samples
                    r_neg   <= w_diff[DIFF_W-1];
                    r_quo   <= {w_diff_abs, 4'b0};
                    r_rem   <= '0;
                    r_den   <= DEN_W'(w_slope) * DEN_W'(AVG_SAMPLES);
                    r_step  <= STEP_W'(MAG_W);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // One quotient bit per cycle
                    r_rem  <= w_fit ? (w_shift - {1'b0, r_den}) : w_shift;
                    r_quo  <= {r_quo[MAG_W-2:0], w_fit};
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == STEP_W'(1)) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    // A negative quotient skips the pulse; a truncated zero does not
                    if (r_neg && (r_quo != '0)) begin
                        np = off_next(r_start_settle, PH_INIT_SETTLE);
                        r_phase <= np.phase;
                        r_cnt   <= np.cnt;
                    end else begin
                        r_phase <= PH_INIT_PULSE;
                        r_cnt   <= r_neg ? '0 : CNT_W'(w_quo_sat);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {r_res_phase, w_temp_ext[TEMP_W-1:0], r_res_heater};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Heater pulse regulator testbench
// Streams thermistor ticks through the regulator and compares every result
// item with a cycle-free model of the averaging run, the slope-sized initial
// pulse and the regulation loop. Both stream sides idle at random, and the
// registers are rewritten between test phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import hpr_pkg::*;

    localparam int AVG_N        = 100;
    localparam int CNT_BITS     = 16;
    localparam int CODE_BITS    = 10;
    localparam int IN_W         = ((CODE_BITS + 7) / 8) * 8;
    localparam int TICK_GOAL    = 1050;
    localparam int TAIL_TICKS   = 520;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam longint MAX_COUNT = (longint'(1) << CNT_BITS) - 1;

    typedef struct packed {
        logic [PHASE_W-1:0]       phase;
        logic signed [TEMP_W-1:0] temperature;
        logic                     heater_on;
    } t_tick_result;

    // Tracks the regulator state per tick and holds the results still owed.
    class t_heater_tracker;
        logic [6:0]          target_deg;
        logic [4:0]          cutoff_deg;
        logic [4:0]          far_deg;
        logic [9:0]          long_ticks;
        logic [9:0]          short_ticks;
        logic [9:0]          settle_len;
        logic [9:0]          startup_settle_len;
        logic [11:0]         slope;
        logic [PHASE_W-1:0]  phase;
        logic [CNT_BITS-1:0] ticks_left;
        int                  sample_sum;
        logic [6:0]          sample_count;
        logic                heater;
        t_tick_result        expected_ticks[$];
        int                  mismatches;

        function new();
            target_deg         = 7'd45;
            cutoff_deg         = 5'd1;
            far_deg            = 5'd5;
            long_ticks         = 10'd45;
            short_ticks        = 10'd30;
            settle_len         = 10'd10;
            startup_settle_len = 10'd30;
            slope              = 12'd33;
            phase              = PH_AVG;
            ticks_left         = '0;
            sample_sum         = 0;
            sample_count       = '0;
            heater             = 1'b1;
            mismatches         = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_TARGET:       target_deg         = value[6:0];
                CFG_CUTOFF:       cutoff_deg         = value[4:0];
                CFG_FAR:          far_deg            = value[4:0];
                CFG_LONG_PULSE:   long_ticks         = value[9:0];
                CFG_SHORT_PULSE:  short_ticks        = value[9:0];
                CFG_SETTLE:       settle_len         = value[9:0];
                CFG_START_SETTLE: startup_settle_len = value[9:0];
                CFG_SLOPE:        slope              = value;
            endcase
        endfunction

        // A zero-length off phase goes straight to the idle check.
        function void enter_off(input logic [9:0] len, input logic [PHASE_W-1:0] off_phase);
            if (len == '0) begin
                phase      = PH_IDLE;
                ticks_left = '0;
            end else begin
                phase      = off_phase;
                ticks_left = CNT_BITS'(len - 10'd1);
            end
        endfunction

        function void note_tick(input logic [CODE_BITS-1:0] code);
            int unsigned        scaled;
            int                 temp_q;
            int                 tgt_q;
            longint             excess;
            longint             pulse;
            logic [9:0]         up;
            logic [PHASE_W-1:0] tick_phase;
            t_tick_result       r;
            scaled     = code * 587;
            temp_q     = int'(scaled >> 8) - 978;
            tgt_q      = int'(target_deg) * 16;
            tick_phase = phase;
            case (phase)
                PH_AVG: begin
                    heater = 1'b1;
                    sample_sum += temp_q;
                    sample_count += 7'd1;
                    if (sample_count >= AVG_N) begin
                        // Shortfall of the mean, in 1/256 degree, over the slope.
                        excess = (longint'(tgt_q) * AVG_N - longint'(sample_sum)) * 16;
                        pulse = excess / (longint'((slope == '0) ? 12'd1 : slope) * AVG_N);
                        if (pulse < 0) begin
                            enter_off(startup_settle_len, PH_INIT_SETTLE);
                        end else begin
                            if (pulse > MAX_COUNT)
                                pulse = MAX_COUNT;
                            phase      = PH_INIT_PULSE;
                            ticks_left = pulse[CNT_BITS-1:0];
                        end
                    end
                end
                PH_INIT_PULSE, PH_PULSE: begin
                    heater = 1'b1;
                    if (ticks_left == '0) begin
                        if (phase == PH_INIT_PULSE)
                            enter_off(startup_settle_len, PH_INIT_SETTLE);
                        else
                            enter_off(settle_len, PH_SETTLE);
                    end else begin
                        ticks_left -= 1'b1;
                    end
                end
                PH_INIT_SETTLE, PH_SETTLE: begin
                    heater = 1'b0;
                    if (ticks_left == '0)
                        phase = PH_IDLE;
                    else
                        ticks_left -= 1'b1;
                end
                default: begin
                    // Idle check: a tick below the cutoff becomes the first on tick of a pulse.
                    tick_phase = PH_IDLE;
                    phase      = PH_IDLE;
                    if (temp_q < tgt_q - int'(cutoff_deg) * 16) begin
                        tick_phase = PH_PULSE;
                        heater     = 1'b1;
                        up = (temp_q + int'(far_deg) * 16 < tgt_q) ? long_ticks : short_ticks;
                        if (up == '0) begin
                            enter_off(settle_len, PH_SETTLE);
                        end else begin
                            phase      = PH_PULSE;
                            ticks_left = CNT_BITS'(up - 10'd1);
                        end
                    end else begin
                        heater = 1'b0;
                    end
                end
            endcase
            r.heater_on   = heater;
            r.temperature = temp_q[TEMP_W-1:0];
            r.phase       = tick_phase;
            expected_ticks.push_back(r);
        endfunction

        function void check_result(input logic [OUT_W-1:0] data);
            t_tick_result want;
            if (expected_ticks.size() == 0) begin
                $error("Result item 0x%h arrived with no tick outstanding", data);
                mismatches++;
            end else begin
                want = expected_ticks.pop_front();
                if (data[0] !== want.heater_on) begin
                    $error("heater_on: expected %0d, got %0d", want.heater_on, data[0]);
                    mismatches++;
                end
                if (data[12:1] !== want.temperature) begin
                    $error("temperature: expected %0d, got %0d",
                           want.temperature, $signed(data[12:1]));
                    mismatches++;
                end
                if (data[15:13] !== want.phase) begin
                    $error("phase: expected %0d, got %0d", want.phase, data[15:13]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    t_heater_tracker tracker = new();
    bit            no_idle = 1'b0;
    int            ticks_sent = 0;
    int            quiet_cycles = 0;

    heater_pulse_regulator #(
        .AVG_SAMPLES (AVG_N),
        .COUNT_BITS  (CNT_BITS),
        .ADC_BITS    (CODE_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Ends the run when no item moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Nearest converter code for a temperature in 1/16 degree.
    function automatic logic [CODE_BITS-1:0] code_near(input int temp_q);
        int c;
        c = ((temp_q + 978) * 256 + 293) / 587;
        if (c < 0)
            c = 0;
        else if (c > 1023)
            c = 1023;
        return c[CODE_BITS-1:0];
    endfunction

    function automatic logic [4:0] margin_pick();
        case ($urandom_range(0, 5))
            0:       return 5'd0;
            1:       return 5'd31;
            default: return 5'($urandom_range(0, 8));
        endcase
    endfunction

    function automatic logic [9:0] pulse_len_pick();
        if ($urandom_range(0, 3) == 0)
            return 10'd0;
        return 10'($urandom_range(1, 12));
    endfunction

    // Sends one tick; valid stays high into the next item when no gap is drawn.
    task automatic send_tick(input logic [CODE_BITS-1:0] code);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(code);
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_tick(code);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, value);
    endtask

    // Writes every register; unused upper data bits carry random junk.
    task automatic configure(input logic [6:0] target, input logic [4:0] cutoff,
                             input logic [4:0] far, input logic [9:0] long_len,
                             input logic [9:0] short_len, input logic [9:0] settle,
                             input logic [9:0] start_settle, input logic [11:0] slope);
        write_reg(CFG_TARGET,       {5'($urandom), target});
        write_reg(CFG_CUTOFF,       {7'($urandom), cutoff});
        write_reg(CFG_FAR,          {7'($urandom), far});
        write_reg(CFG_LONG_PULSE,   {2'($urandom), long_len});
        write_reg(CFG_SHORT_PULSE,  {2'($urandom), short_len});
        write_reg(CFG_SETTLE,       {2'($urandom), settle});
        write_reg(CFG_START_SETTLE, {2'($urandom), start_settle});
        write_reg(CFG_SLOPE,        slope);
        i_cfg_valid <= 1'b0;
    endtask

    // Stops sending and waits until every owed result item has been taken.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.expected_ticks.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stall before each item, then take it and check it.
    initial begin : result_sink
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            tracker.check_result(m_axis_tdata);
        end
    end

    initial begin : stimulus
        int          scenario;
        int          tgt_q;
        int          n;
        int          pick;
        logic [6:0]  t_deg;
        logic [4:0]  cut;
        logic [4:0]  far;
        logic [9:0]  st;
        logic [11:0] slope;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Startup: the averaging run, the initial pulse and its settle. The
        // slope and the sample band keep the initial pulse short; one setting
        // drives a hot average so that the pulse length comes out negative.
        scenario = $urandom_range(0, 3);
        case (scenario)
            0: begin
                t_deg = 7'($urandom_range(0, 127));
                slope = 12'd4095;
            end
            1: begin
                t_deg = 7'($urandom_range(0, 85));
                slope = 12'd0;
            end
            2: begin
                t_deg = 7'($urandom_range(0, 85));
                slope = 12'd1;
            end
            default: begin
                t_deg = 7'($urandom_range(0, 38));
                slope = 12'($urandom_range(1, 1000));
            end
        endcase
        st = ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom_range(1, 15));
        configure(t_deg, margin_pick(), margin_pick(), pulse_len_pick(), pulse_len_pick(),
                  pulse_len_pick(), st, slope);
        tgt_q = int'(t_deg) * 16;
        while (tracker.phase != PH_IDLE) begin
            case (scenario)
                0:       send_tick(CODE_BITS'($urandom));
                1, 2:    send_tick(code_near(tgt_q + int'($urandom_range(0, 8)) - 4));
                default: send_tick(CODE_BITS'($urandom_range(800, 1023)));
            endcase
        end

        // Zero pulse and settle lengths: a pulse start drops straight back to idle.
        drain();
        configure(7'd40, 5'd0, 5'd0, 10'd0, 10'd0, 10'd0, 10'd0, 12'd4095);
        send_tick('0);
        send_tick('1);
        send_tick(code_near(640) - CODE_BITS'(1));
        send_tick(code_near(640));
        send_tick(code_near(640) + CODE_BITS'(1));

        // Long and short pulses with a one-tick settle.
        drain();
        configure(7'd40, 5'd0, 5'd31, 10'd2, 10'd1, 10'd1, 10'd1023, 12'd1);
        send_tick(code_near(100));
        send_tick('1);
        send_tick('0);
        send_tick(10'd512);
        send_tick('1);
        send_tick(code_near(400));
        send_tick(code_near(400));
        send_tick('0);
        send_tick('1);
        send_tick(code_near(639));

        // Target and margins at their extremes.
        drain();
        configure(7'd127, 5'd31, 5'd0, 10'd1, 10'd3, 10'd0, 10'd0, 12'd4095);
        repeat (4) send_tick('1);
        drain();
        configure(7'd0, 5'd31, 5'd31, 10'd1, 10'd1, 10'd1, 10'd0, 12'd0);
        send_tick('0);
        repeat (3) send_tick('1);
        send_tick(code_near(-497));

        // Random phases: mostly temperatures around the regulation band.
        while (ticks_sent + TAIL_TICKS + 60 < TICK_GOAL) begin
            drain();
            pick = $urandom_range(0, 9);
            t_deg = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd127 :
                    (pick == 2) ? 7'd85 : 7'($urandom_range(0, 85));
            cut = margin_pick();
            far = margin_pick();
            configure(t_deg, cut, far, pulse_len_pick(), pulse_len_pick(), pulse_len_pick(),
                      10'($urandom), 12'($urandom));
            no_idle = ($urandom_range(0, 3) == 0);
            tgt_q = int'(t_deg) * 16;
            n = $urandom_range(40, 120);
            repeat (n) begin
                if ($urandom_range(0, 9) < 7)
                    send_tick(code_near(tgt_q - (int'(far) + 4) * 16 +
                              int'($urandom_range(0, (int'(far) + int'(cut) + 6) * 16))));
                else
                    send_tick(CODE_BITS'($urandom));
            end
        end

        // One long pulse or settle with the top bit of the length register set.
        no_idle = 1'b0;
        while (tracker.phase != PH_IDLE) send_tick(CODE_BITS'($urandom));
        drain();
        pick = $urandom_range(0, 2);
        configure(7'd85, 5'd0, (pick == 1) ? 5'd31 : 5'd0,
                  (pick == 0) ? 10'(TAIL_TICKS) : 10'd0,
                  (pick == 1) ? 10'(TAIL_TICKS) : 10'd0,
                  (pick == 2) ? 10'(TAIL_TICKS) : 10'd0, 10'd0, 12'd4095);
        send_tick((pick == 1) ? code_near(1100) : CODE_BITS'(0));
        while (tracker.phase != PH_IDLE) send_tick(CODE_BITS'($urandom));

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
